// ===== hdl/fsft_pkg.sv =====
// Shared types and constants for the frame slot fence tracker.
// No dependencies; every other file of the block but fsft_ram refers to this package.
package fsft_pkg;

  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned EPOCH_W    = 64;
  localparam int unsigned RANK_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned GRANT_W    = 3;
  localparam int unsigned RC_W       = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SEEN_W     = 4;
  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 4'd15;
  localparam logic [RC_W-1:0]   RC_RESET = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_SUBMIT  = 2'd1,
    OP_RETIRE  = 2'd2,
    OP_CANCEL  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [SLOT_W-1:0]  slot;
    logic [EPOCH_W-1:0] epoch;
    logic [RANK_W-1:0]  rank;
    logic [VALUE_W-1:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic acq_ok;
    logic clear_done;
  } dp_stat_t;

endpackage

// ===== hdl/frame_slot_fence_tracker.sv =====
// Frame slot fence tracker, top level. Depends on fsft_pkg, fsft_ctrl, fsft_dp.
// Each item goes through its steps in order: load, then execute against the registered RAM read;
// a granted acquire then clears its fence row in the fence RAM. A new item is accepted
// only after the previous one has gone through all of its steps.
// Execute waits while the previous result is still held in the output register.
// Reset: asynchronous; all slots free, rank_count = 1, no clearing pass needed.
module frame_slot_fence_tracker #(
  parameter int unsigned FRAME_SLOTS = 8,
  parameter int unsigned MAX_RANKS   = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot[7:0], epoch[71:8], rank[79:72], value[143:80]
  input  logic [fsft_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [fsft_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ok[0], granted_slot[3:1], any_pending[4], zero[7:5]
  output logic [fsft_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fsft_pkg::RC_W-1:0]        cfg_data_i
);

  fsft_pkg::ctrl_cmd_t cmd;
  fsft_pkg::dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  fsft_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  fsft_dp #(
    .FRAME_SLOTS(FRAME_SLOTS),
    .MAX_RANKS  (MAX_RANKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  a_result_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without an executing item");

  a_grant_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3:1] == 3'd0))
    else $error("nonzero granted slot on a rejected transaction");

endmodule

// ===== hdl/fsft_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fsft_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fsft_ctrl.sv =====
// Sequencer of the frame slot fence tracker: load, execute, row clear.
// Depends on fsft_pkg for the command and status structs.
module fsft_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fsft_pkg::dp_stat_t   stat_i,
  output fsft_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.acq_ok ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

// ===== hdl/fsft_dp.sv =====
// Datapath of the frame slot fence tracker: slot table, fence memory, run state,
// result register. Depends on fsft_pkg and fsft_ram.
module fsft_dp #(
  parameter int unsigned FRAME_SLOTS = 8,
  parameter int unsigned MAX_RANKS   = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fsft_pkg::ctrl_cmd_t                cmd_i,
  output fsft_pkg::dp_stat_t                 stat_o,
  input  logic [fsft_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic [fsft_pkg::OP_W-1:0]          in_user_i,
  input  logic                               in_last_i,
  input  logic                               cfg_valid_i,
  input  logic [fsft_pkg::RC_W-1:0]          cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fsft_pkg::OUT_DATA_W-1:0]    out_data_o
);

  localparam int unsigned SW  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int unsigned RW  = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int unsigned FD  = FRAME_SLOTS * MAX_RANKS;
  localparam int unsigned FAW = (FD > 1) ? $clog2(FD) : 1;

  localparam logic [fsft_pkg::CNT_W-1:0]  MAX_N    = fsft_pkg::CNT_W'(MAX_RANKS);
  localparam logic [fsft_pkg::SLOT_W-1:0] SLOT_LIM = fsft_pkg::SLOT_W'(FRAME_SLOTS);
  localparam logic [RW-1:0]               CLR_END  = RW'(MAX_RANKS - 1);

  fsft_pkg::item_t item_q;

  logic [fsft_pkg::RC_W-1:0]    rank_count_q;
  logic [FRAME_SLOTS-1:0]       busy_q, busy_d;
  logic [FRAME_SLOTS-1:0]       any_sub_q, any_sub_d;
  logic [fsft_pkg::EPOCH_W-1:0] newest_epoch_q, newest_epoch_d;
  logic [fsft_pkg::VALUE_W-1:0] newest_fence_q [MAX_RANKS];
  logic [fsft_pkg::VALUE_W-1:0] newest_fence_d [MAX_RANKS];
  logic [fsft_pkg::SEEN_W-1:0]  seen_q, seen_d;
  logic                         bad_q, bad_d;
  logic                         anyr_q, anyr_d;
  logic [RW-1:0]                clr_cnt_q;
  logic [SW-1:0]                clr_row_q;
  logic                         out_valid_q;
  logic [fsft_pkg::OUT_DATA_W-1:0] out_data_q;

  logic [fsft_pkg::SLOT_W-1:0]  in_slot;
  logic [SW-1:0]                slot_idx, free_idx;
  logic [RW-1:0]                rank_idx;
  logic [FAW-1:0]               rd_addr, sub_addr, clr_addr, fw_addr;
  logic [fsft_pkg::VALUE_W-1:0] fw_data, fence_rdata, fence_sub;
  logic [fsft_pkg::EPOCH_W-1:0] epoch_rdata;
  logic                         fw_we, ep_we;
  logic [fsft_pkg::CNT_W-1:0]   eff_n;
  logic                         free_any, slot_in, ticket_ok, pos_in, sub_live;
  logic                         acq_cond, sub_cond, run_bad, run_any, len_ok;
  logic                         emit, res_ok, acq_ok;
  logic [fsft_pkg::GRANT_W-1:0] res_grant;

  // Read addresses come straight from the bus during the load cycle
  assign in_slot = in_data_i[fsft_pkg::SLOT_W-1:0];
  assign rd_addr = FAW'(in_slot[SW-1:0]) * FAW'(MAX_RANKS) + FAW'(seen_q[RW-1:0]);

  assign slot_idx = item_q.slot[SW-1:0];
  assign rank_idx = item_q.rank[RW-1:0];
  assign sub_addr = FAW'(slot_idx) * FAW'(MAX_RANKS) + FAW'(rank_idx);
  assign clr_addr = FAW'(clr_row_q) * FAW'(MAX_RANKS) + FAW'(clr_cnt_q);

  fsft_ram #(
    .WIDTH(fsft_pkg::EPOCH_W),
    .DEPTH(FRAME_SLOTS)
  ) u_epoch_ram (
    .clk_i  (clk_i),
    .we_i   (ep_we),
    .waddr_i(free_idx),
    .wdata_i(item_q.epoch),
    .re_i   (cmd_i.load),
    .raddr_i(in_slot[SW-1:0]),
    .rdata_o(epoch_rdata)
  );

  fsft_ram #(
    .WIDTH(fsft_pkg::VALUE_W),
    .DEPTH(FD)
  ) u_fence_ram (
    .clk_i  (clk_i),
    .we_i   (fw_we),
    .waddr_i(fw_addr),
    .wdata_i(fw_data),
    .re_i   (cmd_i.load),
    .raddr_i(rd_addr),
    .rdata_o(fence_rdata)
  );

  always_comb begin
    eff_n = {1'b0, rank_count_q};
    if (eff_n > MAX_N) begin
      eff_n = MAX_N;
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  // rows of free slots read as zero; a row is cleared again on acquire
  assign sub_live  = slot_in && busy_q[slot_idx];
  assign fence_sub = sub_live ? fence_rdata : '0;

  assign free_any  = ~&busy_q;
  assign slot_in   = item_q.slot < SLOT_LIM;
  assign ticket_ok = slot_in && (item_q.epoch != '0) && busy_q[slot_idx] &&
                     (epoch_rdata == item_q.epoch);
  assign acq_cond  = (item_q.epoch != '0) && (item_q.epoch > newest_epoch_q) && free_any;
  assign sub_cond  = ticket_ok && (item_q.rank < fsft_pkg::RANK_W'(eff_n)) &&
                     (item_q.value != '0) && (item_q.value > newest_fence_q[rank_idx]);
  assign pos_in    = {1'b0, seen_q} < eff_n;
  assign run_bad   = bad_q || !slot_in || (pos_in && (item_q.value < fence_sub));
  assign run_any   = anyr_q || (pos_in && (fence_sub != '0));
  assign len_ok    = ({1'b0, seen_q} + fsft_pkg::CNT_W'(1)) == eff_n;

  always_comb begin
    busy_d         = busy_q;
    any_sub_d      = any_sub_q;
    newest_epoch_d = newest_epoch_q;
    newest_fence_d = newest_fence_q;
    seen_d         = seen_q;
    bad_d          = bad_q;
    anyr_d         = anyr_q;
    emit           = 1'b0;
    res_ok         = 1'b0;
    res_grant      = '0;
    acq_ok         = 1'b0;
    ep_we          = 1'b0;
    fw_we          = 1'b0;
    fw_addr        = clr_addr;
    fw_data        = '0;
    if (cmd_i.exec) begin
      if (item_q.op != fsft_pkg::OP_RETIRE) begin
        seen_d = '0;
        bad_d  = 1'b0;
        anyr_d = 1'b0;
      end
      unique case (item_q.op)
        fsft_pkg::OP_ACQUIRE: begin
          emit = 1'b1;
          if (acq_cond) begin
            acq_ok              = 1'b1;
            res_ok              = 1'b1;
            res_grant           = fsft_pkg::GRANT_W'(free_idx);
            busy_d[free_idx]    = 1'b1;
            any_sub_d[free_idx] = 1'b0;
            newest_epoch_d      = item_q.epoch;
            ep_we               = 1'b1;
          end
        end
        fsft_pkg::OP_SUBMIT: begin
          emit = 1'b1;
          if (sub_cond) begin
            res_ok                   = 1'b1;
            fw_we                    = 1'b1;
            fw_addr                  = sub_addr;
            fw_data                  = item_q.value;
            newest_fence_d[rank_idx] = item_q.value;
            any_sub_d[slot_idx]      = 1'b1;
          end
        end
        fsft_pkg::OP_RETIRE: begin
          if (!item_q.last) begin
            anyr_d = run_any;
            if (seen_q == fsft_pkg::SEEN_MAX) begin
              bad_d = 1'b1;
            end else begin
              bad_d  = run_bad;
              seen_d = seen_q + fsft_pkg::SEEN_W'(1);
            end
          end else begin
            emit   = 1'b1;
            seen_d = '0;
            bad_d  = 1'b0;
            anyr_d = 1'b0;
            if (ticket_ok && len_ok && !run_bad && run_any) begin
              res_ok           = 1'b1;
              busy_d[slot_idx] = 1'b0;
            end
          end
        end
        fsft_pkg::OP_CANCEL: begin
          emit = 1'b1;
          if (ticket_ok && !any_sub_q[slot_idx]) begin
            res_ok           = 1'b1;
            busy_d[slot_idx] = 1'b0;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    if (cmd_i.clear) begin
      fw_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q   <= fsft_pkg::RC_RESET;
      busy_q         <= '0;
      any_sub_q      <= '0;
      newest_epoch_q <= '0;
      for (int i = 0; i < MAX_RANKS; i++) begin
        newest_fence_q[i] <= '0;
      end
      seen_q         <= '0;
      bad_q          <= 1'b0;
      anyr_q         <= 1'b0;
      clr_cnt_q      <= '0;
      clr_row_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rank_count_q <= cfg_data_i;
      end
      busy_q         <= busy_d;
      any_sub_q      <= any_sub_d;
      newest_epoch_q <= newest_epoch_d;
      newest_fence_q <= newest_fence_d;
      seen_q         <= seen_d;
      bad_q          <= bad_d;
      anyr_q         <= anyr_d;
      if (acq_ok) begin
        clr_row_q <= free_idx;
        clr_cnt_q <= '0;
      end else if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + RW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q.op    <= fsft_pkg::op_e'(in_user_i);
      item_q.slot  <= in_slot;
      item_q.epoch <= in_data_i[71:8];
      item_q.rank  <= in_data_i[79:72];
      item_q.value <= in_data_i[143:80];
      item_q.last  <= in_last_i;
    end
    if (emit) begin
      out_data_q <= {3'b000, |busy_d, res_grant, res_ok};
    end
  end

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.acq_ok     = acq_ok;
  assign stat_o.clear_done = (clr_cnt_q == CLR_END);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
